FILE: src/modular_inverse_ext_euclid_top_defines.svh
// Assertion helpers used by the checker module miee_checker.
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_DEFINES_SVH

// same-cycle implication
`define MIEE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MIEE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/miee_pkg.sv
`default_nettype none
package miee_pkg;

	localparam int DATA_WIDTH = 31;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_SETUP,
		OP_ALIGN,
		OP_SUB,
		OP_SWAP,
		OP_PASS,
		OP_FAIL
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_M_ZERO,
		C_R1_ZERO,
		C_CAN_SHIFT,
		C_B_NE_R1,
		C_R0_NE_ONE
	} cond_t;

	typedef enum logic [2:0] {
		A_INIT,
		A_TEST,
		A_ALIGN,
		A_SUB,
		A_SWAP,
		A_CHECK,
		A_PASS,
		A_FAIL
	} addr_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		addr_t target;
		logic  last;
	} uword_t;

	typedef struct packed {
		logic m_zero;
		logic r1_zero;
		logic can_shift;
		logic b_ne_r1;
		logic r0_ne_one;
	} flags_t;

	typedef struct packed {
		logic load;
		logic exec;
		op_t  op;
	} dp_ctrl_t;

	function automatic uword_t ucode(addr_t a);
		uword_t w;
		unique case (a)
			A_INIT:  w = '{op: OP_NOP,   cond: C_M_ZERO,    target: A_FAIL,  last: 1'b0};
			A_TEST:  w = '{op: OP_SETUP, cond: C_R1_ZERO,   target: A_CHECK, last: 1'b0};
			A_ALIGN: w = '{op: OP_ALIGN, cond: C_CAN_SHIFT, target: A_ALIGN, last: 1'b0};
			A_SUB:   w = '{op: OP_SUB,   cond: C_B_NE_R1,   target: A_SUB,   last: 1'b0};
			A_SWAP:  w = '{op: OP_SWAP,  cond: C_ALWAYS,    target: A_TEST,  last: 1'b0};
			A_CHECK: w = '{op: OP_NOP,   cond: C_R0_NE_ONE, target: A_FAIL,  last: 1'b0};
			A_PASS:  w = '{op: OP_PASS,  cond: C_NEXT,      target: A_INIT,  last: 1'b1};
			A_FAIL:  w = '{op: OP_FAIL,  cond: C_NEXT,      target: A_INIT,  last: 1'b1};
			default: w = '{op: OP_FAIL,  cond: C_NEXT,      target: A_INIT,  last: 1'b1};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: src/miee_sequencer.sv
`default_nettype none
module miee_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  miee_pkg::flags_t   flags,
	output miee_pkg::dp_ctrl_t ctrl
);
	import miee_pkg::*;

	logic   busy_q;
	logic   out_valid_q;
	addr_t  pc_q;
	addr_t  pc_d;
	uword_t uw;
	logic   stall;
	logic   exec;
	logic   take;
	logic   jump;

	always_comb begin
		uw    = ucode(pc_q);
		stall = uw.last && out_valid_q && !out_ready;
		exec  = busy_q && !stall;
		take  = in_valid && !busy_q;
	end

	always_comb begin
		unique case (uw.cond)
			C_NEXT:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_M_ZERO:    jump = flags.m_zero;
			C_R1_ZERO:   jump = flags.r1_zero;
			C_CAN_SHIFT: jump = flags.can_shift;
			C_B_NE_R1:   jump = flags.b_ne_r1;
			C_R0_NE_ONE: jump = flags.r0_ne_one;
			default:     jump = 1'b0;
		endcase
		pc_d = jump ? uw.target : addr_t'(3'(pc_q) + 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= A_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				pc_q   <= A_INIT;
			end else if (exec) begin
				if (uw.last) begin
					busy_q <= 1'b0;
				end
				pc_q <= pc_d;
			end
			if (exec && uw.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;

	always_comb begin
		ctrl.load = take;
		ctrl.exec = exec;
		ctrl.op   = uw.op;
	end
endmodule
`default_nettype wire

FILE: src/miee_datapath.sv
`default_nettype none
module miee_datapath (
	input  logic               clk,
	input  miee_pkg::dp_ctrl_t ctrl,
	input  miee_pkg::word_t    value,
	input  miee_pkg::word_t    modulus,
	output miee_pkg::flags_t   flags,
	output miee_pkg::word_t    inverse,
	output logic               exists
);
	import miee_pkg::*;

	word_t r0_q;
	word_t r1_q;
	word_t t0_q;
	word_t t1_q;
	word_t b_q;
	word_t c_q;
	logic  odd_q;
	word_t inv_q;
	logic  exists_q;

	word_t b_dbl;
	logic  r0_ge_b;
	word_t t_red;
	word_t inv_calc;

	always_comb begin
		b_dbl   = {b_q[DATA_WIDTH-2:0], 1'b0};
		r0_ge_b = r0_q >= b_q;
		flags.m_zero    = modulus == '0;
		flags.r1_zero   = r1_q == '0;
		flags.can_shift = !b_q[DATA_WIDTH-1] && (b_dbl <= r0_q);
		flags.b_ne_r1   = b_q != r1_q;
		flags.r0_ne_one = r0_q != word_t'(1);
		t_red = (t0_q == modulus) ? '0 : t0_q;
		if (odd_q || t_red == '0) begin
			inv_calc = t_red;
		end else begin
			inv_calc = modulus - t_red;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			r0_q  <= modulus;
			r1_q  <= value;
			t0_q  <= '0;
			t1_q  <= word_t'(1);
			odd_q <= 1'b0;
		end else if (ctrl.exec) begin
			unique case (ctrl.op)
				OP_NOP: begin
				end
				OP_SETUP: begin
					b_q <= r1_q;
					c_q <= t1_q;
				end
				OP_ALIGN: begin
					if (flags.can_shift) begin
						b_q <= b_dbl;
						c_q <= {c_q[DATA_WIDTH-2:0], 1'b0};
					end
				end
				OP_SUB: begin
					if (r0_ge_b) begin
						r0_q <= r0_q - b_q;
						t0_q <= t0_q + c_q;
					end
					if (flags.b_ne_r1) begin
						b_q <= b_q >> 1;
						c_q <= c_q >> 1;
					end
				end
				OP_SWAP: begin
					r0_q  <= r1_q;
					r1_q  <= r0_q;
					t0_q  <= t1_q;
					t1_q  <= t0_q;
					odd_q <= !odd_q;
				end
				OP_PASS: begin
					inv_q    <= inv_calc;
					exists_q <= 1'b1;
				end
				OP_FAIL: begin
					inv_q    <= '0;
					exists_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign inverse = inv_q;
	assign exists  = exists_q;
endmodule
`default_nettype wire

FILE: src/modular_inverse_ext_euclid_top.sv
// Modular inverse by the extended Euclidean algorithm.
// Input channel in_valid/in_ready carries value; output channel
// out_valid/out_ready carries inverse and exists. modulus is written through
// modulus_we; the user must write it only while the block is idle, which the
// block itself does not enforce. It resets to 1.
// An item is taken when in_valid and in_ready are high; in_ready is high
// whenever the sequencer is idle, also while a finished result waits.
// Each Euclid step runs TEST, ALIGN (repeated while the doubled divisor
// still fits in r0), SUB (repeated until the divisor is back to r1) and SWAP.
// A TEST that finds a zero remainder ends the loop; INIT comes before the
// loop, and CHECK and the result step come after it.
// A new value is taken only once the sequencer has finished the last one.
// When out_ready is low the result register holds and the sequencer waits
// on its final step. Reset clears the sequencer and the output valid flag.
`default_nettype none
module modular_inverse_ext_euclid_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  miee_pkg::word_t value,
	output logic            out_valid,
	input  logic            out_ready,
	output miee_pkg::word_t inverse,
	output logic            exists,
	input  logic            modulus_we,
	input  miee_pkg::word_t modulus
);
	import miee_pkg::*;

	word_t    modulus_q;
	flags_t   flags;
	dp_ctrl_t ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= word_t'(1);
		end else if (modulus_we) begin
			modulus_q <= modulus;
		end
	end

	miee_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.ctrl      (ctrl)
	);

	miee_datapath u_dp (
		.clk     (clk),
		.ctrl    (ctrl),
		.value   (value),
		.modulus (modulus_q),
		.flags   (flags),
		.inverse (inverse),
		.exists  (exists)
	);
endmodule
`default_nettype wire

FILE: src/miee_checker.sv
`default_nettype none
`include "modular_inverse_ext_euclid_top_defines.svh"
module miee_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input miee_pkg::word_t inverse,
	input logic            exists
);
	`MIEE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`MIEE_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(inverse) && $stable(exists), "result changed while stalled")
	`MIEE_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after transfer")
	`MIEE_ASSERT_IMP(a_zero_when_none, out_valid && !exists, inverse == '0, "nonzero inverse without exists")
endmodule

bind modular_inverse_ext_euclid_top miee_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.inverse   (inverse),
	.exists    (exists)
);
`default_nettype wire

FILE: verif/modular_inverse_ext_euclid_top_tb.sv
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_top_tb;
	import miee_pkg::word_t;
	import miee_pkg::DATA_WIDTH;

	localparam int STEP_CAP = 2 * DATA_WIDTH + 8;
	localparam word_t WORD_MAX = '1;

	typedef struct packed {
		word_t inv;
		logic  ok;
	} inv_result_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	word_t value = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	word_t inverse;
	logic  exists;
	logic  modulus_we = 1'b0;
	word_t modulus = word_t'(1);

	word_t       pending_values[$];
	inv_result_t expected_inverses[$];
	word_t       cur_modulus = word_t'(1);
	int          values_queued = 0;
	int          results_seen = 0;
	int          mismatch_count = 0;
	logic        in_fire = 1'b0;

	modular_inverse_ext_euclid_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.inverse    (inverse),
		.exists     (exists),
		.modulus_we (modulus_we),
		.modulus    (modulus)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic inv_result_t predict_inverse(word_t val, word_t m);
		bit [63:0] r0, r1, t0, t1, q, nxt;
		int unsigned steps;
		inv_result_t res;
		res.inv = '0;
		res.ok = 1'b0;
		if (m == 0)
			return res;
		r0 = 64'(m);
		r1 = 64'(val);
		t0 = '0;
		t1 = 64'd1;
		steps = 0;
		for (int i = 0; i < STEP_CAP && r1 != 0; i++) begin
			q = r0 / r1;
			nxt = r0 - q * r1;
			r0 = r1;
			r1 = nxt;
			nxt = t0 + q * t1;
			t0 = t1;
			t1 = nxt;
			steps++;
		end
		if (r0 != 1)
			return res;
		// odd step count leaves a positive coefficient, even a negative one
		if (steps[0])
			nxt = t0 % 64'(m);
		else
			nxt = (64'(m) - (t0 % 64'(m))) % 64'(m);
		res.inv = nxt[DATA_WIDTH-1:0];
		res.ok = 1'b1;
		return res;
	endfunction

	function automatic word_t random_value(word_t m);
		bit [63:0] mm, v;
		int unsigned d;
		mm = 64'(m);
		case ($urandom_range(0, 5))
			0, 1: v = 64'($urandom);
			2: v = 64'($urandom_range(0, 40));
			3: v = (mm > 64'd8) ? mm - 64'($urandom_range(1, 8))
				: 64'($urandom_range(0, 8));
			4: begin
				d = $urandom_range(2, 30);
				if (mm % 64'(d) == 64'd0)
					v = 64'(d * $urandom_range(1, 1 << 20));
				else
					v = mm * 64'($urandom_range(0, 2));
			end
			default: v = mm * 64'($urandom_range(1, 3)) + 64'($urandom_range(0, 3));
		endcase
		return v[DATA_WIDTH-1:0];
	endfunction

	task automatic issue(input word_t v);
		pending_values.insert(pending_values.size(), v);
		values_queued++;
	endtask

	task automatic drain();
		while (results_seen != values_queued)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_modulus(input word_t m);
		drain();
		modulus_we <= 1'b1;
		modulus <= m;
		cur_modulus = m;
		@(negedge clk);
		modulus_we <= 1'b0;
	endtask

	task automatic issue_random(input int n);
		repeat (n) issue(random_value(cur_modulus));
	endtask

	// input driver: bursts of transfers separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_values.size() > 0) begin
				if (burst_left == 0)
					burst_left = $urandom_range(1, 16);
				in_valid <= 1'b1;
				value <= pending_values.pop_front();
				burst_left--;
				if (burst_left == 0) begin
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 4);
						2: gap_left = $urandom_range(5, 40);
						default: gap_left = $urandom_range(41, 260);
					endcase
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output backpressure: modes held for random spans
	int stall_mode = 0;
	int stall_span = 0;

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(5, 80);
		end
		stall_span--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 5) == 0);
			default: out_ready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready)
			expected_inverses.insert(expected_inverses.size(),
				predict_inverse(value, cur_modulus));
	end

	always @(posedge clk) begin : check_results
		inv_result_t want;
		if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_inverses.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: inverse=%0d exists=%0b", inverse, exists);
				mismatch_count++;
			end else begin
				want = expected_inverses.pop_front();
				if (inverse !== want.inv || exists !== want.ok) begin
					if (mismatch_count < 10)
						$display("mismatch: inverse exp %0d got %0d, exists exp %0b got %0b",
							want.inv, inverse, want.ok, exists);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		word_t m;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		issue('0);
		issue(WORD_MAX);
		issue(word_t'(7));

		set_modulus(WORD_MAX);
		issue('0);
		issue(word_t'(1));
		issue(word_t'(2));
		issue(WORD_MAX - word_t'(1));
		issue(WORD_MAX);
		issue(word_t'(31'h2AAAAAAA));
		issue(word_t'(31'h55555555));
		issue(word_t'(12345));
		issue_random(15);

		// consecutive Fibonacci numbers give the longest remainder chain
		set_modulus(word_t'(1836311903));
		issue(word_t'(1134903170));
		issue(word_t'(1836311902));
		issue(word_t'(1836311904));
		issue('0);
		issue_random(15);

		set_modulus(word_t'(1));
		issue('0);
		issue(word_t'(1));
		issue(word_t'(31'h40000000));
		issue_random(15);

		set_modulus(word_t'(2));
		issue('0);
		issue(word_t'(1));
		issue(word_t'(2));
		issue(word_t'(3));
		issue_random(15);

		set_modulus(word_t'(12));
		issue(word_t'(5));
		issue(word_t'(6));
		issue(word_t'(11));
		issue_random(15);

		repeat (9) begin
			case ($urandom_range(0, 3))
				0: m = word_t'($urandom_range(2, 2147483647));
				1: m = word_t'($urandom_range(2, 200));
				2: m = word_t'(1) << $urandom_range(1, 30);
				default: m = word_t'($urandom_range(1 << 20, 2147483647) | 1);
			endcase
			set_modulus(m);
			issue_random(50);
		end

		while (results_seen != values_queued)
			@(negedge clk);
		repeat (300) @(negedge clk);

		if (mismatch_count == 0 && expected_inverses.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
